### hw/rtl/pdc_pkg.sv
package pdc_pkg;

  // Fixed field widths of the stream and config port
  localparam int unsigned VALUE_W      = 10;
  localparam int unsigned DIFF_W       = 10;
  localparam int unsigned PAIR_TOTAL_W = 32;
  localparam int unsigned S_TDATA_W    = 16;

  // Parameter defaults
  localparam int unsigned VALUE_BITS_DEF = 10;
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned TOTAL_BITS_DEF = 32;

  // Set tag stored with each histogram entry; tag zero never matches a live set
  localparam int unsigned EPOCH_BITS = 8;

  // Result queue depth: one slot for the result in flight, two for back-to-back flow
  localparam int unsigned OUT_FIFO_DEPTH = 3;

  typedef enum logic {
    ST_SWEEP,
    ST_RUN
  } pdc_state_e;

endpackage

### hw/rtl/pdc_out_fifo.sv
module pdc_out_fifo #(
  parameter int unsigned DATA_BITS = pdc_pkg::PAIR_TOTAL_W,
  parameter int unsigned DEPTH     = pdc_pkg::OUT_FIFO_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [DATA_BITS-1:0]         push_data_i,
  output logic [$clog2(DEPTH+1)-1:0]   count_o,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [DATA_BITS-1:0]         m_axis_tdata
);
  import pdc_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [DATA_BITS-1:0] slot_q [DEPTH];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 pop;

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = slot_q[rd_ptr_q];
  assign count_o       = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hw/rtl/pair_difference_counter.sv
// Counts pairs of values in a set whose absolute difference equals the configured
// difference. Takes one value per clock while s_axis_tready is high; the running pair
// total for each value is formed in stage 1 from the registered value and pushed into
// the result queue, which offers it. s_axis_tready drops while three results are queued
// or in flight, so output backpressure stalls the input.
// The histogram sits in two copies of a 2^VALUE_BITS-entry synchronous RAM (one read
// for each neighbor, one for the value itself), written back in the cycle after the read
// with a one-deep bypass. Each entry carries a set tag so a new set (tuser high) starts
// without touching the RAM. After reset every RAM entry is cleared by a sweep with
// s_axis_tready low. On the 255th new set since the last clearing pass the in-flight item
// drains and the same sweep runs, with s_axis_tready low, before that set is taken.
// Config writes are taken throughout.
// Counts and the total saturate.
module pair_difference_counter #(
  parameter int unsigned VALUE_BITS = pdc_pkg::VALUE_BITS_DEF,
  parameter int unsigned COUNT_BITS = pdc_pkg::COUNT_BITS_DEF,
  parameter int unsigned TOTAL_BITS = pdc_pkg::TOTAL_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pdc_pkg::DIFF_W-1:0]        cfg_wdata_i,     // difference
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [pdc_pkg::S_TDATA_W-1:0]     s_axis_tdata,    // [9:0] value, rest zero
  input  logic                              s_axis_tuser,    // [0] first
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [pdc_pkg::PAIR_TOTAL_W-1:0]  m_axis_tdata     // [31:0] pair_total
);
  import pdc_pkg::*;

  localparam int unsigned Depth  = 1 << VALUE_BITS;
  localparam int unsigned WordW  = EPOCH_BITS + COUNT_BITS;
  localparam int unsigned AddW   = ((VALUE_BITS > DIFF_W) ? VALUE_BITS : DIFF_W) + 1;
  localparam int unsigned SumW   = ((TOTAL_BITS > COUNT_BITS) ? TOTAL_BITS : COUNT_BITS) + 2;
  localparam int unsigned FifoCntW = $clog2(OUT_FIFO_DEPTH + 1);

  // ---------------- config
  logic [DIFF_W-1:0] diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_q <= '0;
    end else if (cfg_we_i) begin
      diff_q <= cfg_wdata_i;
    end
  end

  // ---------------- control
  pdc_state_e           state_q, state_d;
  logic [VALUE_BITS-1:0] sweep_cnt_q, sweep_cnt_d;
  logic [EPOCH_BITS-1:0] epoch_q, epoch_d;
  logic                  wrap_req;
  logic                  room;
  logic                  sweep_active;
  logic                  accept;
  logic [FifoCntW-1:0]   fifo_count;
  logic [FifoCntW:0]     occupancy;

  logic                  s1_valid_q;

  assign wrap_req  = s_axis_tvalid && s_axis_tuser && (epoch_q == '1);
  assign occupancy = {1'b0, fifo_count} + (FifoCntW+1)'(s1_valid_q);
  assign room      = occupancy < (FifoCntW+1)'(OUT_FIFO_DEPTH);
  assign accept    = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SWEEP: begin
        if (sweep_cnt_q == '1) state_d = ST_RUN;
      end
      ST_RUN: begin
        // tags are exhausted: drain the in-flight item, then clear
        if (wrap_req && !s1_valid_q) state_d = ST_SWEEP;
      end
      default: state_d = ST_SWEEP;
    endcase
  end

  always_comb begin
    sweep_active  = (state_q == ST_SWEEP);
    s_axis_tready = (state_q == ST_RUN) && !wrap_req && room;
  end

  always_comb begin
    sweep_cnt_d = sweep_active ? sweep_cnt_q + VALUE_BITS'(1) : '0;
    epoch_d     = epoch_q;
    if (sweep_active) begin
      epoch_d = EPOCH_BITS'(1);
    end else if (accept && s_axis_tuser) begin
      epoch_d = epoch_q + EPOCH_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_cnt_q <= '0;
      epoch_q     <= EPOCH_BITS'(1);
    end else begin
      state_q     <= state_d;
      sweep_cnt_q <= sweep_cnt_d;
      epoch_q     <= epoch_d;
    end
  end

  // ---------------- stage 0: address generation and RAM read
  logic [VALUE_BITS+DIFF_W-1:0] value_ext;
  logic [VALUE_BITS-1:0]        x_addr;
  logic [AddW-1:0]              x_w, k_w, lo_w, hi_w;
  logic                         lo_en, hi_en, self_en;

  always_comb begin
    value_ext = {VALUE_BITS'(0), s_axis_tdata[VALUE_W-1:0]};
    x_addr    = value_ext[VALUE_BITS-1:0];
    x_w       = AddW'(x_addr);
    k_w       = AddW'(diff_q);
    lo_w      = x_w - k_w;
    hi_w      = x_w + k_w;
    self_en   = (diff_q == '0);
    lo_en     = !self_en && (k_w <= x_w);
    hi_en     = !self_en && (hi_w[AddW-1:VALUE_BITS] == '0);
  end

  logic [VALUE_BITS-1:0] s1_x_q, s1_lo_q, s1_hi_q;
  logic                  s1_lo_en_q, s1_hi_en_q, s1_self_q, s1_first_q;
  logic [EPOCH_BITS-1:0] s1_epoch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q     <= x_addr;
      s1_lo_q    <= lo_w[VALUE_BITS-1:0];
      s1_hi_q    <= hi_w[VALUE_BITS-1:0];
      s1_lo_en_q <= lo_en;
      s1_hi_en_q <= hi_en;
      s1_self_q  <= self_en;
      s1_first_q <= s_axis_tuser;
      s1_epoch_q <= s_axis_tuser ? epoch_q + EPOCH_BITS'(1) : epoch_q;
    end
  end

  // Histogram RAMs: nbr_mem serves both neighbors, self_mem the value itself.
  logic [WordW-1:0]      nbr_mem  [Depth];
  logic [WordW-1:0]      self_mem [Depth];
  logic [WordW-1:0]      rd_lo_q, rd_hi_q, rd_x_q;
  logic                  mem_we;
  logic [VALUE_BITS-1:0] mem_waddr;
  logic [WordW-1:0]      mem_wdata;

  always_ff @(posedge clk_i) begin
    rd_lo_q <= nbr_mem[lo_w[VALUE_BITS-1:0]];
    rd_hi_q <= nbr_mem[hi_w[VALUE_BITS-1:0]];
    rd_x_q  <= self_mem[x_addr];
    if (mem_we) begin
      nbr_mem[mem_waddr]  <= mem_wdata;
      self_mem[mem_waddr] <= mem_wdata;
    end
  end

  // ---------------- stage 1: bypass, update, write back
  logic                  fw_valid_q;
  logic [VALUE_BITS-1:0] fw_addr_q;
  logic [WordW-1:0]      fw_word_q;

  logic [WordW-1:0]      word_lo, word_hi, word_x;
  logic [COUNT_BITS-1:0] cnt_lo, cnt_hi, cnt_x, cnt_new;
  logic [TOTAL_BITS-1:0] total_q, total_d, total_base;
  logic [SumW-1:0]       sum;
  logic [TOTAL_BITS+PAIR_TOTAL_W-1:0] total_ext;

  always_comb begin
    word_lo = (fw_valid_q && fw_addr_q == s1_lo_q) ? fw_word_q : rd_lo_q;
    word_hi = (fw_valid_q && fw_addr_q == s1_hi_q) ? fw_word_q : rd_hi_q;
    word_x  = (fw_valid_q && fw_addr_q == s1_x_q)  ? fw_word_q : rd_x_q;
    // an entry tagged with another set reads as zero
    cnt_lo  = (word_lo[WordW-1:COUNT_BITS] == s1_epoch_q) ? word_lo[COUNT_BITS-1:0] : '0;
    cnt_hi  = (word_hi[WordW-1:COUNT_BITS] == s1_epoch_q) ? word_hi[COUNT_BITS-1:0] : '0;
    cnt_x   = (word_x[WordW-1:COUNT_BITS]  == s1_epoch_q) ? word_x[COUNT_BITS-1:0]  : '0;
    cnt_new = (cnt_x == '1) ? cnt_x : cnt_x + COUNT_BITS'(1);

    total_base = s1_first_q ? '0 : total_q;
    sum = SumW'(total_base)
        + (s1_lo_en_q ? SumW'(cnt_lo) : '0)
        + (s1_hi_en_q ? SumW'(cnt_hi) : '0)
        + (s1_self_q  ? SumW'(cnt_x)  : '0);
    total_d   = (sum[SumW-1:TOTAL_BITS] != '0) ? '1 : sum[TOTAL_BITS-1:0];
    total_ext = {PAIR_TOTAL_W'(0), total_d};

    mem_we    = sweep_active || s1_valid_q;
    mem_waddr = sweep_active ? sweep_cnt_q : s1_x_q;
    mem_wdata = sweep_active ? '0 : {s1_epoch_q, cnt_new};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= '0;
      fw_valid_q <= 1'b0;
    end else begin
      if (s1_valid_q) total_q <= total_d;
      fw_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fw_addr_q <= s1_x_q;
    fw_word_q <= {s1_epoch_q, cnt_new};
  end

  // ---------------- result queue
  pdc_out_fifo #(
    .DATA_BITS (PAIR_TOTAL_W),
    .DEPTH     (OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (s1_valid_q),
    .push_data_i   (total_ext[PAIR_TOTAL_W-1:0]),
    .count_o       (fifo_count),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

### hw/rtl/pdc_checker.sv
module pdc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [pdc_pkg::PAIR_TOTAL_W-1:0]  m_axis_tdata
);

  // result stays offered until taken
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("m_axis_tvalid dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("m_axis_tdata changed while stalled");

  // clearing pass holds off input right after reset
  a_sweep_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("input taken during clearing pass");

  // a result appears only after an input transaction has passed stage 1 and the result queue, never from nothing
  a_out_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without matching input transaction");

endmodule

bind pair_difference_counter pdc_checker u_pdc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
